FILE: src/mlm_pkg.sv
package mlm_pkg;

    localparam int NUM_MUTEXES_DEF = 32;
    localparam int NUM_TASKS_DEF   = 64;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2
    } mlm_op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DEADLOCK  = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_NONE_FREE = 3'd4,
        ST_QUEUED    = 3'd5
    } mlm_status_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic signed [7:0] mutex_index;
        logic [5:0]        task_id;
        logic [5:0]        native_priority;
    } mlm_req_t;

    typedef struct packed {
        mlm_status_t status;
        logic [4:0]  created_index;
        logic        woken_valid;
        logic [5:0]  woken_task;
        logic        priority_valid;
        logic [5:0]  new_priority;
    } mlm_rsp_t;

endpackage

FILE: src/mlm_ram.sv
module mlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/mutex_lock_manager_top.sv
// Mutex lock manager. Requests (create, lock, unlock) arrive as beats on the
// s_ channel and each one produces exactly one result beat on the m_ channel,
// in request order. Both channels use valid/ready.
// A request is registered when accepted, and its mutex and task entries are
// fetched from the per-task memories in the same edge. Once the result register
// is free or being taken, the request is resolved in one pass and the result
// lands in the output register, which drives m_valid. One request per cycle is
// taken as long as the receiver keeps m_ready high.
// When the receiver stalls, the result register holds its beat, the request
// register fills behind it, and s_ready drops until the result is taken.
// Reset frees all mutexes, clears the lock and queue-occupancy flags and sets
// every task's held count to zero; queue links need no clearing.
// Held counts are kept as per-task acquire and release counters whose
// difference is the number of mutexes the task holds, so that an unlock with
// a handoff touches each counter memory only once.
module mutex_lock_manager_top #(
    parameter int NUM_MUTEXES = mlm_pkg::NUM_MUTEXES_DEF,
    parameter int NUM_TASKS   = mlm_pkg::NUM_TASKS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mlm_pkg::mlm_req_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mlm_pkg::mlm_rsp_t m_data
);

    import mlm_pkg::*;

    localparam int MUTEX_AW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int TASK_AW  = $clog2(NUM_TASKS);
    localparam int CNT_W    = $clog2(NUM_MUTEXES + 1);

    logic                   in_valid_reg, in_valid_next;
    logic                   out_valid_reg, out_valid_next;
    mlm_req_t               req_reg;
    mlm_rsp_t               rsp_reg, rsp_next;
    logic [5:0]             w_reg;
    logic                   acq_a_hit_reg, acq_b_hit_reg, rel_hit_reg, nw_hit_reg;
    logic [CNT_W-1:0]       acq_byp_reg, rel_byp_reg;
    logic [5:0]             nw_byp_reg;

    logic [NUM_MUTEXES-1:0] allocated_reg, allocated_next;
    logic [NUM_MUTEXES-1:0] locked_reg, locked_next;
    logic [NUM_MUTEXES-1:0] nonempty_reg, nonempty_next;
    logic [5:0]             holder_reg [NUM_MUTEXES];
    logic [5:0]             holder_next [NUM_MUTEXES];
    logic [5:0]             queue_head_reg [NUM_MUTEXES];
    logic [5:0]             queue_head_next [NUM_MUTEXES];
    logic [5:0]             queue_tail_reg [NUM_MUTEXES];
    logic [5:0]             queue_tail_next [NUM_MUTEXES];
    logic [NUM_TASKS-1:0]   acq_vld_reg, acq_vld_next;
    logic [NUM_TASKS-1:0]   rel_vld_reg, rel_vld_next;

    logic                   accept, stage_fire;
    logic [MUTEX_AW-1:0]    s_m, m;
    logic [TASK_AW-1:0]     s_task_addr, t_addr, w_addr, head_addr;
    logic [5:0]             head_fetch;
    logic                   m_ok, t_ok, any_free;
    logic [NUM_MUTEXES-1:0] free_vec, free_low;
    logic [MUTEX_AW-1:0]    free_idx;

    logic [CNT_W-1:0]       acq_a_rdata, acq_b_rdata, rel_rdata;
    logic [5:0]             nw_rdata;
    logic [CNT_W-1:0]       acq_t, acq_w, rel_t, held_after;
    logic [5:0]             nw_w;

    logic                   acq_we, rel_we, nw_we;
    logic [TASK_AW-1:0]     acq_waddr, nw_waddr;
    logic [CNT_W-1:0]       acq_wdata, rel_wdata;
    logic [5:0]             nw_wdata;

    assign stage_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || stage_fire;
    assign accept     = s_valid && s_ready;

    assign m   = MUTEX_AW'($unsigned(req_reg.mutex_index));
    assign t_addr = TASK_AW'(req_reg.task_id);
    assign w_addr = TASK_AW'(w_reg);
    assign m_ok = !req_reg.mutex_index[7]
                  && ({1'b0, $unsigned(req_reg.mutex_index)} < 9'(NUM_MUTEXES));
    assign t_ok = {3'b000, req_reg.task_id} < 9'(NUM_TASKS);

    assign acq_t = acq_vld_reg[t_addr] ? (acq_a_hit_reg ? acq_byp_reg : acq_a_rdata) : '0;
    assign acq_w = acq_vld_reg[w_addr] ? (acq_b_hit_reg ? acq_byp_reg : acq_b_rdata) : '0;
    assign rel_t = rel_vld_reg[t_addr] ? (rel_hit_reg ? rel_byp_reg : rel_rdata) : '0;
    assign nw_w  = nw_hit_reg ? nw_byp_reg : nw_rdata;
    assign held_after = acq_t - rel_t - CNT_W'(1);

    assign free_vec = ~allocated_reg;
    assign free_low = free_vec & (~free_vec + NUM_MUTEXES'(1));
    assign any_free = |free_vec;

    always_comb begin
        free_idx = '0;
        for (int i = 0; i < NUM_MUTEXES; i++) begin
            if (free_low[i]) begin
                free_idx = free_idx | MUTEX_AW'(i);
            end
        end
    end

    always_comb begin
        allocated_next  = allocated_reg;
        locked_next     = locked_reg;
        nonempty_next   = nonempty_reg;
        holder_next     = holder_reg;
        queue_head_next = queue_head_reg;
        queue_tail_next = queue_tail_reg;
        acq_we    = 1'b0;
        acq_waddr = t_addr;
        acq_wdata = acq_t + CNT_W'(1);
        rel_we    = 1'b0;
        rel_wdata = rel_t + CNT_W'(1);
        nw_we     = 1'b0;
        nw_waddr  = TASK_AW'(queue_tail_reg[m]);
        nw_wdata  = req_reg.task_id;
        rsp_next        = '0;
        rsp_next.status = ST_INVALID;
        if (stage_fire) begin
            case (req_reg.operation)
                OP_CREATE: begin
                    if (any_free) begin
                        allocated_next[free_idx] = 1'b1;
                        rsp_next.status        = ST_OK;
                        rsp_next.created_index = 5'(free_idx);
                    end else begin
                        rsp_next.status = ST_NONE_FREE;
                    end
                end
                OP_LOCK: begin
                    if (m_ok && t_ok && allocated_reg[m]) begin
                        if (locked_reg[m] && holder_reg[m] == req_reg.task_id) begin
                            rsp_next.status = ST_DEADLOCK;
                        end else if (locked_reg[m]) begin
                            if (nonempty_reg[m]) begin
                                nw_we = 1'b1;
                            end else begin
                                queue_head_next[m] = req_reg.task_id;
                                nonempty_next[m]   = 1'b1;
                            end
                            queue_tail_next[m] = req_reg.task_id;
                            rsp_next.status    = ST_QUEUED;
                        end else begin
                            locked_next[m] = 1'b1;
                            holder_next[m] = req_reg.task_id;
                            acq_we         = 1'b1;
                            rsp_next.status         = ST_OK;
                            rsp_next.priority_valid = 1'b1;
                        end
                    end
                end
                OP_UNLOCK: begin
                    if (m_ok && t_ok && allocated_reg[m]) begin
                        if (!locked_reg[m] || holder_reg[m] != req_reg.task_id) begin
                            rsp_next.status = ST_NOT_OWNER;
                        end else begin
                            rsp_next.status = ST_OK;
                            rel_we          = 1'b1;
                            if (held_after == '0) begin
                                rsp_next.priority_valid = 1'b1;
                                rsp_next.new_priority   = req_reg.native_priority;
                            end
                            if (nonempty_reg[m]) begin
                                if (w_reg == queue_tail_reg[m]) begin
                                    nonempty_next[m] = 1'b0;
                                end else begin
                                    queue_head_next[m] = nw_w;
                                end
                                holder_next[m] = w_reg;
                                acq_we         = 1'b1;
                                acq_waddr      = w_addr;
                                acq_wdata      = acq_w + CNT_W'(1);
                                rsp_next.woken_valid = 1'b1;
                                rsp_next.woken_task  = w_reg;
                            end else begin
                                locked_next[m] = 1'b0;
                                holder_next[m] = '0;
                            end
                        end
                    end
                end
                default: begin
                    rsp_next.status = ST_INVALID;
                end
            endcase
        end
    end

    always_comb begin
        acq_vld_next = acq_vld_reg;
        rel_vld_next = rel_vld_reg;
        if (acq_we) begin
            acq_vld_next[acq_waddr] = 1'b1;
        end
        if (rel_we) begin
            rel_vld_next[t_addr] = 1'b1;
        end
    end

    assign s_m         = MUTEX_AW'($unsigned(s_data.mutex_index));
    assign s_task_addr = TASK_AW'(s_data.task_id);
    assign head_fetch  = queue_head_next[s_m];
    assign head_addr   = TASK_AW'(head_fetch);

    assign in_valid_next  = accept || (in_valid_reg && !stage_fire);
    assign out_valid_next = stage_fire || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            allocated_reg <= '0;
            locked_reg    <= '0;
            nonempty_reg  <= '0;
            holder_reg    <= '{default: '0};
            acq_vld_reg   <= '0;
            rel_vld_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            allocated_reg <= allocated_next;
            locked_reg    <= locked_next;
            nonempty_reg  <= nonempty_next;
            holder_reg    <= holder_next;
            acq_vld_reg   <= acq_vld_next;
            rel_vld_reg   <= rel_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        queue_head_reg <= queue_head_next;
        queue_tail_reg <= queue_tail_next;
        if (accept) begin
            req_reg       <= s_data;
            w_reg         <= head_fetch;
            acq_a_hit_reg <= acq_we && (acq_waddr == s_task_addr);
            acq_b_hit_reg <= acq_we && (acq_waddr == head_addr);
            rel_hit_reg   <= rel_we && (t_addr == s_task_addr);
            nw_hit_reg    <= nw_we && (nw_waddr == head_addr);
            acq_byp_reg   <= acq_wdata;
            rel_byp_reg   <= rel_wdata;
            nw_byp_reg    <= nw_wdata;
        end
        if (stage_fire) begin
            rsp_reg <= rsp_next;
        end
    end

    mlm_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TASKS)) u_acq_a (
        .aclk    (aclk),
        .wr_en   (acq_we),
        .wr_addr (acq_waddr),
        .wr_data (acq_wdata),
        .rd_en   (accept),
        .rd_addr (s_task_addr),
        .rd_data (acq_a_rdata)
    );

    mlm_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TASKS)) u_acq_b (
        .aclk    (aclk),
        .wr_en   (acq_we),
        .wr_addr (acq_waddr),
        .wr_data (acq_wdata),
        .rd_en   (accept),
        .rd_addr (head_addr),
        .rd_data (acq_b_rdata)
    );

    mlm_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TASKS)) u_rel (
        .aclk    (aclk),
        .wr_en   (rel_we),
        .wr_addr (t_addr),
        .wr_data (rel_wdata),
        .rd_en   (accept),
        .rd_addr (s_task_addr),
        .rd_data (rel_rdata)
    );

    mlm_ram #(.WIDTH(6), .DEPTH(NUM_TASKS)) u_next_waiter (
        .aclk    (aclk),
        .wr_en   (nw_we),
        .wr_addr (nw_waddr),
        .wr_data (nw_wdata),
        .rd_en   (accept),
        .rd_addr (head_addr),
        .rd_data (nw_rdata)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = rsp_reg;

endmodule
